/* rtl/spcf_pkg.sv */
// Package for the stereo punch and crossfeed unit: defaults, config register
// indexes, sequencer state and multiplier operation codes.
// No dependencies; compile first.
package spcf_pkg;

	localparam int DELAY_MAX_DEF   = 256;
	localparam int SAMPLE_BITS_DEF = 24;

	localparam int COEF_W     = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int ENABLES_W  = 2;
	localparam int DLEN_W     = 9;

	localparam logic [DLEN_W-1:0] DLEN_RESET = DLEN_W'(1);

	// enable bit positions
	localparam int ENA_PUNCH = 0;
	localparam int ENA_ROOM  = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLES,
		CFG_EDGE_BLEND,
		CFG_TRANS_BOOST,
		CFG_ENV_ATTACK,
		CFG_ENV_RELEASE,
		CFG_ROOM_GAIN,
		CFG_ROOM_LOWPASS,
		CFG_DELAY_LENGTH
	} spcf_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} spcf_state_t;

	// one shared multiply per op, issued in this order
	typedef enum logic [3:0] {
		OP_ENV_L,
		OP_EDGE_L,
		OP_TRANS_L,
		OP_ENV_R,
		OP_EDGE_R,
		OP_TRANS_R,
		OP_LP_L,
		OP_LP_R,
		OP_GAIN_L,
		OP_GAIN_R
	} spcf_op_t;

endpackage

/* rtl/spcf_if.sv */
// Channel interfaces of the stereo punch and crossfeed unit: frame input,
// result output and configuration write. Depends on spcf_pkg.
interface spcf_frame_if #(parameter int SAMPLE_BITS = spcf_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface spcf_result_if #(parameter int SAMPLE_BITS = spcf_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface spcf_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [spcf_pkg::CFG_IDX_W-1:0]   index;
	logic [spcf_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/spcf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module spcf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/stereo_punch_and_crossfeed_unit.sv */
// Stereo punch and crossfeed unit: per-frame transient shaping and delayed,
// lowpassed opposite-channel bleed. Depends on spcf_pkg, spcf_if, spcf_ram.
//
// channel  | dir | payload                 | accept
// ---------+-----+-------------------------+--------------------------
// frame    | in  | left_in, right_in       | frame.valid & frame.ready
// result   | out | left_out, right_out     | result.valid & result.ready
// cfg      | in  | index, data             | cfg.valid (ready tied high)
//
// A frame is taken only once the last is through: ten products through one
// shared 17 x (SAMPLE_BITS+1) multiplier, the drain state, the load of the
// output register, which waits on a stalled result, and idle for the next beat.
// After reset the delay RAM is swept to zero with frame.ready low. A result
// waiting in the output register does not block the next accept; a second
// finished result waits in the sequencer until it drains.
module stereo_punch_and_crossfeed_unit #(
	parameter int DELAY_MAX   = spcf_pkg::DELAY_MAX_DEF,
	parameter int SAMPLE_BITS = spcf_pkg::SAMPLE_BITS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	spcf_frame_if.sink        frame,
	spcf_result_if.source     result,
	spcf_cfg_if.sink          cfg
);
	import spcf_pkg::*;

	localparam int S   = SAMPLE_BITS;
	localparam int VW  = S + 1;            // operand width
	localparam int PW  = COEF_W + 1 + VW;  // product width
	localparam int RW  = PW - 16;          // rounded product width
	localparam int AW  = S + 3;            // accumulator width
	localparam int ADW = $clog2(DELAY_MAX);
	localparam int LW  = ($clog2(DELAY_MAX + 1) > DLEN_W) ? $clog2(DELAY_MAX + 1) : DLEN_W;

	localparam logic signed [PW-1:0] RND_HALF = PW'(1) << 15;
	localparam logic signed [AW-1:0] SAT_HI   = {{(AW-S+1){1'b0}}, {(S-1){1'b1}}};
	localparam logic signed [AW-1:0] SAT_LO   = {{(AW-S+1){1'b1}}, {(S-1){1'b0}}};

	function automatic logic signed [AW-1:0] sat_fn(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI;
		end else if (v < SAT_LO) begin
			r = SAT_LO;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// configuration
	logic [ENABLES_W-1:0] enables_q;
	logic [COEF_W-1:0]    edge_blend_q, trans_boost_q, env_attack_q, env_release_q;
	logic [COEF_W-1:0]    room_gain_q, room_lowpass_q;
	logic [DLEN_W-1:0]    dlen_q;

	// sequencer
	spcf_state_t          state_q, state_nx;
	spcf_op_t             op_q;
	logic [ADW-1:0]       clr_q;
	logic                 in_rdy, issue, load_out, clr_last, clearing, accept;

	// filter state
	logic signed [S-1:0]  prev_l_q, prev_r_q;
	logic signed [VW-1:0] env_l_q, env_r_q;
	logic signed [S-1:0]  filt_l_q, filt_r_q;
	logic [ADW-1:0]       pos_q, cur_pos_q;

	// working registers
	logic signed [S-1:0]  xl_q, xr_q;
	logic signed [AW-1:0] accl_q, accr_q;

	// multiplier
	logic signed [COEF_W:0] mul_coef;
	logic signed [VW-1:0]   mul_val, mul_base;
	logic signed [PW-1:0]   mul_p, prod_s1, prod_rnd;
	logic signed [VW-1:0]   base_s1;
	spcf_op_t               op_s1;
	logic                   mvld_s1;
	logic signed [RW-1:0]   rnd, base_sum;
	logic signed [AW-1:0]   accl_sum, accr_sum;

	// output register
	logic                 res_vld_q;
	logic signed [S-1:0]  left_q, right_q;

	// delay RAM
	logic                 ram_we;
	logic [ADW-1:0]       ram_waddr, pos_eff, pos_next;
	logic [2*S-1:0]       ram_wdata, ram_rdata;
	logic signed [S-1:0]  dly_l, dly_r;
	logic [LW-1:0]        len_raw, len_eff;

	logic                 punch_en, room_en;
	logic signed [VW-1:0] xl_ext, xr_ext, magl, magr;

	assign punch_en = enables_q[ENA_PUNCH];
	assign room_en  = enables_q[ENA_ROOM];
	assign cfg.ready = 1'b1;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enables_q      <= '0;
			edge_blend_q   <= '0;
			trans_boost_q  <= '0;
			env_attack_q   <= '0;
			env_release_q  <= '0;
			room_gain_q    <= '0;
			room_lowpass_q <= '0;
			dlen_q         <= DLEN_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_ENABLES:      enables_q      <= cfg.data[ENABLES_W-1:0];
				CFG_EDGE_BLEND:   edge_blend_q   <= cfg.data[COEF_W-1:0];
				CFG_TRANS_BOOST:  trans_boost_q  <= cfg.data[COEF_W-1:0];
				CFG_ENV_ATTACK:   env_attack_q   <= cfg.data[COEF_W-1:0];
				CFG_ENV_RELEASE:  env_release_q  <= cfg.data[COEF_W-1:0];
				CFG_ROOM_GAIN:    room_gain_q    <= cfg.data[COEF_W-1:0];
				CFG_ROOM_LOWPASS: room_lowpass_q <= cfg.data[COEF_W-1:0];
				CFG_DELAY_LENGTH: dlen_q         <= cfg.data[DLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	assign clr_last = (clr_q == ADW'(DELAY_MAX - 1));
	assign accept   = frame.valid && in_rdy;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_last) state_nx = ST_IDLE;
			ST_IDLE:  if (accept) state_nx = ST_RUN;
			ST_RUN:   if (op_q == OP_GAIN_R) state_nx = ST_DRAIN;
			ST_DRAIN: state_nx = ST_DONE;
			ST_DONE:  if (load_out) state_nx = ST_IDLE;
			default:  state_nx = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_rdy   = 1'b0;
		issue    = 1'b0;
		load_out = 1'b0;
		clearing = 1'b0;
		unique case (state_q)
			ST_CLEAR: clearing = 1'b1;
			ST_IDLE:  in_rdy = 1'b1;
			ST_RUN:   issue = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  load_out = !res_vld_q || result.ready;
			default:  ;
		endcase
	end

	assign frame.ready = in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			op_q    <= OP_ENV_L;
			clr_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				op_q <= OP_ENV_L;
			end else if (issue && op_q != OP_GAIN_R) begin
				op_q <= spcf_op_t'(op_q + 1'b1);
			end
		end
	end

	// ---------------- delay position ----------------
	assign len_raw = LW'(dlen_q);

	always_comb begin
		if (len_raw == '0) begin
			len_eff = LW'(1);
		end else if (len_raw > LW'(DELAY_MAX)) begin
			len_eff = LW'(DELAY_MAX);
		end else begin
			len_eff = len_raw;
		end
	end

	assign pos_eff  = (LW'(pos_q) < len_eff) ? pos_q : '0;
	assign pos_next = ((LW'(cur_pos_q) + LW'(1)) >= len_eff) ? '0 : ADW'(cur_pos_q + 1'b1);

	// ---------------- delay RAM ----------------
	assign ram_we    = clearing || (issue && op_q == OP_GAIN_L && room_en);
	assign ram_waddr = clearing ? clr_q : cur_pos_q;
	assign ram_wdata = clearing ? '0 : {accl_q[S-1:0], accr_q[S-1:0]};
	assign dly_l     = ram_rdata[2*S-1:S];
	assign dly_r     = ram_rdata[S-1:0];

	spcf_ram #(
		.WIDTH(2 * S),
		.DEPTH(DELAY_MAX)
	) u_dly_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (pos_eff),
		.rdata (ram_rdata)
	);

	// ---------------- operand select ----------------
	assign xl_ext = VW'(xl_q);
	assign xr_ext = VW'(xr_q);
	assign magl   = xl_q[S-1] ? -xl_ext : xl_ext;
	assign magr   = xr_q[S-1] ? -xr_ext : xr_ext;

	always_comb begin
		logic [COEF_W-1:0]    coef;
		logic signed [VW-1:0] excess;
		coef     = '0;
		mul_val  = '0;
		mul_base = '0;
		excess   = '0;
		case (op_q)
			OP_ENV_L: begin
				if (magl > env_l_q) begin
					coef = env_attack_q; mul_val = magl - env_l_q; mul_base = env_l_q;
				end else begin
					coef = env_release_q; mul_val = env_l_q - magl; mul_base = magl;
				end
			end
			OP_EDGE_L: begin
				coef = edge_blend_q; mul_val = xl_ext - VW'(prev_l_q);
			end
			OP_TRANS_L: begin
				excess  = magl - env_l_q;
				coef    = trans_boost_q;
				mul_val = excess[VW-1] ? '0 : excess;
			end
			OP_ENV_R: begin
				if (magr > env_r_q) begin
					coef = env_attack_q; mul_val = magr - env_r_q; mul_base = env_r_q;
				end else begin
					coef = env_release_q; mul_val = env_r_q - magr; mul_base = magr;
				end
			end
			OP_EDGE_R: begin
				coef = edge_blend_q; mul_val = xr_ext - VW'(prev_r_q);
			end
			OP_TRANS_R: begin
				excess  = magr - env_r_q;
				coef    = trans_boost_q;
				mul_val = excess[VW-1] ? '0 : excess;
			end
			// left bleed filters the delayed right channel, and vice versa
			OP_LP_L: begin
				coef = room_lowpass_q; mul_val = VW'(filt_l_q) - VW'(dly_r);
				mul_base = VW'(dly_r);
			end
			OP_LP_R: begin
				coef = room_lowpass_q; mul_val = VW'(filt_r_q) - VW'(dly_l);
				mul_base = VW'(dly_l);
			end
			OP_GAIN_L: begin
				coef = room_gain_q; mul_val = VW'(filt_l_q);
			end
			OP_GAIN_R: begin
				coef = room_gain_q; mul_val = VW'(filt_r_q);
			end
			default: ;
		endcase
		mul_coef = $signed({1'b0, coef});
	end

	assign mul_p = mul_coef * mul_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvld_s1 <= 1'b0;
		end else begin
			mvld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			prod_s1 <= mul_p;
			base_s1 <= mul_base;
			op_s1   <= op_q;
		end
	end

	// floor((p + 2^15) / 2^16)
	assign prod_rnd = prod_s1 + RND_HALF;
	assign rnd      = prod_rnd[PW-1:16];
	assign base_sum = RW'(base_s1) + rnd;
	assign accl_sum = accl_q + AW'(rnd);
	assign accr_sum = accr_q + AW'(rnd);

	// ---------------- state updates ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
			env_l_q  <= '0;
			env_r_q  <= '0;
			filt_l_q <= '0;
			filt_r_q <= '0;
			pos_q    <= '0;
		end else begin
			if (issue && punch_en && op_q == OP_EDGE_L) begin
				prev_l_q <= xl_q;
			end
			if (issue && punch_en && op_q == OP_EDGE_R) begin
				prev_r_q <= xr_q;
			end
			if (issue && room_en && op_q == OP_GAIN_L) begin
				pos_q <= pos_next;
			end
			if (mvld_s1) begin
				case (op_s1)
					OP_ENV_L: if (punch_en) env_l_q  <= base_sum[VW-1:0];
					OP_ENV_R: if (punch_en) env_r_q  <= base_sum[VW-1:0];
					OP_LP_L:  if (room_en)  filt_l_q <= base_sum[S-1:0];
					OP_LP_R:  if (room_en)  filt_r_q <= base_sum[S-1:0];
					default: ;
				endcase
			end
		end
	end

	// ---------------- working registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			xl_q      <= frame.left_in;
			xr_q      <= frame.right_in;
			accl_q    <= AW'(frame.left_in);
			accr_q    <= AW'(frame.right_in);
			cur_pos_q <= pos_eff;
		end else if (mvld_s1) begin
			case (op_s1)
				OP_EDGE_L:  if (punch_en) accl_q <= accl_sum;
				OP_TRANS_L: if (punch_en) accl_q <= sat_fn(accl_sum);
				OP_EDGE_R:  if (punch_en) accr_q <= accr_sum;
				OP_TRANS_R: if (punch_en) accr_q <= sat_fn(accr_sum);
				OP_GAIN_L:  if (room_en)  accl_q <= sat_fn(accl_sum);
				OP_GAIN_R:  if (room_en)  accr_q <= sat_fn(accr_sum);
				default: ;
			endcase
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (load_out) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			left_q  <= accl_q[S-1:0];
			right_q <= accr_q[S-1:0];
		end
	end

	assign result.valid     = res_vld_q;
	assign result.left_out  = left_q;
	assign result.right_out = right_q;

endmodule

/* rtl/spcf_checker.sv */
// Port-level checker for the stereo punch and crossfeed unit, bound to the
// top level. Depends on spcf_pkg and stereo_punch_and_crossfeed_unit.
module spcf_checker #(
	parameter int SAMPLE_BITS = spcf_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   frame_valid,
	input logic                   frame_ready,
	input logic                   result_valid,
	input logic                   result_ready,
	input logic [SAMPLE_BITS-1:0] result_left,
	input logic [SAMPLE_BITS-1:0] result_right
);
	localparam logic [1:0] PEND_MAX = 2'd2;

	logic       fr_acc, rs_acc;
	logic [1:0] pend_q;

	assign fr_acc = frame_valid && frame_ready;
	assign rs_acc = result_valid && result_ready;

	// frames taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (fr_acc && !rs_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (rs_acc && !fr_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		fr_acc |-> pend_q != PEND_MAX)
		else $error("frame beat taken with two frames already pending");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != '0)
		else $error("result beat offered with no frame pending");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		fr_acc |=> !frame_ready)
		else $error("frame ready right after a frame beat");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(result_left) && $stable(result_right))
		else $error("stalled result beat changed or dropped");

endmodule

bind stereo_punch_and_crossfeed_unit spcf_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_spcf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.frame_valid  (frame.valid),
	.frame_ready  (frame.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_left  (result.left_out),
	.result_right (result.right_out)
);
